FILE: design/qled_pkg.sv
// Shared types and constants for the quoted literal escape decoder.
package qled_pkg;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       source_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_value;
    logic       escape_bad;
    logic       is_final;
    logic [2:0] literal_status;
    logic       last_of_run;
  } out_item_t;

  // One result without its run marker, as it sits in the queue
  typedef struct packed {
    logic [7:0] char_value;
    logic       escape_bad;
    logic       is_final;
    logic [2:0] literal_status;
  } res_t;

  // All results caused by one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } bundle_t;

  localparam logic [2:0] ST_STRING_OK    = 3'd0;
  localparam logic [2:0] ST_CHAR_OK      = 3'd1;
  localparam logic [2:0] ST_UNTERMINATED = 3'd2;
  localparam logic [2:0] ST_CHAR_LENGTH  = 3'd3;
  localparam logic [2:0] ST_NOT_QUOTE    = 3'd4;

  localparam logic [7:0] BAD_CHAR = 8'hFF;

endpackage

FILE: design/qled_front.sv
// Front end: literal state machine, decodes each byte into a bundle of results.
module qled_front import qled_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_item_t item,
  output logic     q_push,
  output bundle_t  q_data
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BODY = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3,
    PH_OCT  = 3'd4
  } phase_t;

  typedef struct packed {
    logic emit;
    logic fin;
    logic esc;
    res_t res;
  } body_t;

  phase_t     phase_r, phase_nxt;
  logic       sq_r, sq_nxt;
  logic [8:0] ev_r, ev_nxt;
  logic [3:0] dc_r, dc_nxt;
  logic [1:0] dl_r, dl_nxt;
  logic [1:0] n;
  res_t       r0, r1;
  body_t      bd_cur, bd_inc;
  logic [7:0] b;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic       is_oct;
  logic       esc_known;
  logic [7:0] esc_val;

  function automatic logic [1:0] sat_inc(input logic [1:0] d);
    return (d < 2'd2) ? d + 2'd1 : d;
  endfunction

  function automatic res_t mk_char(input logic [7:0] v, input logic bad);
    res_t r;
    r.char_value     = v;
    r.escape_bad     = bad;
    r.is_final       = 1'b0;
    r.literal_status = ST_STRING_OK;
    return r;
  endfunction

  function automatic res_t mk_final(input logic [2:0] st);
    res_t r;
    r.char_value     = 8'd0;
    r.escape_bad     = 1'b0;
    r.is_final       = 1'b1;
    r.literal_status = st;
    return r;
  endfunction

  function automatic res_t oct_res(input logic [8:0] v);
    return v[8] ? mk_char(BAD_CHAR, 1'b1) : mk_char(v[7:0], 1'b0);
  endfunction

  // Ordinary body byte: closing quote, backslash or plain character
  function automatic body_t body_fn(input logic [7:0] c, input logic sq, input logic [1:0] dl);
    body_t   r;
    logic [7:0] q;
    q     = sq ? 8'h27 : 8'h22;
    r.emit = 1'b0;
    r.fin  = 1'b0;
    r.esc  = 1'b0;
    r.res  = mk_char(c, 1'b0);
    if (c == q) begin
      r.emit = 1'b1;
      r.fin  = 1'b1;
      r.res  = mk_final(sq ? ((dl == 2'd1) ? ST_CHAR_OK : ST_CHAR_LENGTH) : ST_STRING_OK);
    end else if (c == 8'h5C) begin
      r.esc = 1'b1;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  assign b      = item.source_byte;
  assign bd_cur = body_fn(b, sq_r, dl_r);
  assign bd_inc = body_fn(b, sq_r, sat_inc(dl_r));
  assign is_oct = (b >= 8'h30) && (b <= 8'h37);

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    esc_known = 1'b1;
    esc_val   = BAD_CHAR;
    unique case (b)
      8'h6E:   esc_val = 8'd10;
      8'h74:   esc_val = 8'd9;
      8'h5C:   esc_val = 8'd92;
      8'h22:   esc_val = 8'd34;
      8'h27:   esc_val = 8'd39;
      8'h72:   esc_val = 8'd13;
      8'h62:   esc_val = 8'd8;
      8'h66:   esc_val = 8'd12;
      8'h76:   esc_val = 8'd11;
      8'h61:   esc_val = 8'd7;
      default: esc_known = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    sq_nxt    = sq_r;
    ev_nxt    = ev_r;
    dc_nxt    = dc_r;
    dl_nxt    = dl_r;
    n         = 2'd0;
    r0        = mk_final(ST_STRING_OK);
    r1        = mk_final(ST_STRING_OK);
    if (acc) begin
      if (phase_r != PH_IDLE && item.source_end) begin
        // Resolve any pending escape, then close as unterminated
        phase_nxt = PH_IDLE;
        ev_nxt    = 9'd0;
        dc_nxt    = 4'd0;
        if (phase_r == PH_BODY) begin
          r0 = mk_final(ST_UNTERMINATED);
          n  = 2'd1;
        end else begin
          r0     = (phase_r == PH_OCT) ? oct_res(ev_r) : mk_char(BAD_CHAR, 1'b1);
          r1     = mk_final(ST_UNTERMINATED);
          dl_nxt = sat_inc(dl_r);
          n      = 2'd2;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (!item.source_end) begin
              if (b == 8'h27 || b == 8'h22) begin
                sq_nxt    = (b == 8'h27);
                dl_nxt    = 2'd0;
                ev_nxt    = 9'd0;
                dc_nxt    = 4'd0;
                phase_nxt = PH_BODY;
              end else begin
                r0     = mk_final(ST_NOT_QUOTE);
                n      = 2'd1;
                ev_nxt = 9'd0;
                dc_nxt = 4'd0;
              end
            end
          end
          PH_BODY: begin
            r0 = bd_cur.res;
            n  = {1'b0, bd_cur.emit};
            if (bd_cur.fin) begin
              phase_nxt = PH_IDLE;
              ev_nxt    = 9'd0;
              dc_nxt    = 4'd0;
            end else if (bd_cur.esc) begin
              phase_nxt = PH_ESC;
            end else begin
              dl_nxt = sat_inc(dl_r);
            end
          end
          PH_ESC: begin
            phase_nxt = PH_BODY;
            if (b == 8'h78 || b == 8'h75 || b == 8'h55) begin
              phase_nxt = PH_HEX;
              ev_nxt    = 9'd0;
              dc_nxt    = (b == 8'h78) ? 4'd2 : (b == 8'h75) ? 4'd4 : 4'd8;
            end else if (is_oct) begin
              phase_nxt = PH_OCT;
              ev_nxt    = {6'd0, b[2:0]};
              dc_nxt    = 4'd1;
            end else begin
              r0     = mk_char(esc_val, !esc_known);
              n      = 2'd1;
              dl_nxt = sat_inc(dl_r);
            end
          end
          PH_HEX: begin
            if (hex_ok) begin
              ev_nxt = {1'b0, ev_r[3:0], hex_val};
              dc_nxt = (dc_r != 4'd0) ? dc_r - 4'd1 : dc_r;
              if (dc_r <= 4'd1) begin
                phase_nxt = PH_BODY;
                r0        = mk_char({ev_r[3:0], hex_val}, 1'b0);
                n         = 2'd1;
                dl_nxt    = sat_inc(dl_r);
              end
            end else begin
              // Flag the broken escape, then take the byte again as body
              r0 = mk_char(BAD_CHAR, 1'b1);
              r1 = bd_inc.res;
              n  = bd_inc.emit ? 2'd2 : 2'd1;
              dl_nxt = (bd_inc.emit && !bd_inc.fin) ? sat_inc(sat_inc(dl_r)) : sat_inc(dl_r);
              if (bd_inc.fin) begin
                phase_nxt = PH_IDLE;
                ev_nxt    = 9'd0;
                dc_nxt    = 4'd0;
              end else if (bd_inc.esc) begin
                phase_nxt = PH_ESC;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
          PH_OCT: begin
            if (is_oct) begin
              ev_nxt = {ev_r[5:0], b[2:0]};
              dc_nxt = dc_r + 4'd1;
              if (dc_r >= 4'd2) begin
                phase_nxt = PH_BODY;
                r0        = oct_res({ev_r[5:0], b[2:0]});
                n         = 2'd1;
                dl_nxt    = sat_inc(dl_r);
              end
            end else begin
              r0 = oct_res(ev_r);
              r1 = bd_inc.res;
              n  = bd_inc.emit ? 2'd2 : 2'd1;
              dl_nxt = (bd_inc.emit && !bd_inc.fin) ? sat_inc(sat_inc(dl_r)) : sat_inc(dl_r);
              if (bd_inc.fin) begin
                phase_nxt = PH_IDLE;
                ev_nxt    = 9'd0;
                dc_nxt    = 4'd0;
              end else if (bd_inc.esc) begin
                phase_nxt = PH_ESC;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  assign q_push    = acc && (n != 2'd0);
  assign q_data.two = (n == 2'd2);
  assign q_data.r0  = r0;
  assign q_data.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      sq_r    <= 1'b0;
      ev_r    <= 9'd0;
      dc_r    <= 4'd0;
      dl_r    <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      sq_r    <= sq_nxt;
      ev_r    <= ev_nxt;
      dc_r    <= dc_nxt;
      dl_r    <= dl_nxt;
    end
  end

endmodule

FILE: design/qled_fifo.sv
// Short queue of result bundles between the front and back ends.
module qled_fifo import qled_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    wr,
  input  bundle_t wr_data,
  output logic    full,
  input  logic    rd,
  output bundle_t rd_data,
  output logic    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/qled_back.sv
// Back end: unpacks each queued bundle into one or two result transfers.
module qled_back import qled_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  bundle_t   head,
  input  logic      q_empty,
  output logic      q_pop,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item
);

  logic sub_r, sub_nxt;
  res_t cur;
  logic take;

  assign empty = q_empty;
  assign take  = pop && !q_empty;
  assign cur   = sub_r ? head.r1 : head.r0;

  assign out_item.char_value     = cur.char_value;
  assign out_item.escape_bad     = cur.escape_bad;
  assign out_item.is_final       = cur.is_final;
  assign out_item.literal_status = cur.literal_status;
  assign out_item.last_of_run    = sub_r || !head.two;

  // Hold the bundle for a second transfer when it carries two results
  always_comb begin
    sub_nxt = sub_r;
    q_pop   = 1'b0;
    if (take) begin
      if (!sub_r && head.two) begin
        sub_nxt = 1'b1;
      end else begin
        sub_nxt = 1'b0;
        q_pop   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

FILE: design/quoted_literal_escape_decoder_unit.sv
// Quoted literal escape decoder, top level.
// Each result passes through the registered bundle queue before it reaches the output.
// Throughput: one byte per cycle while the queue is not full; a byte with two results takes two output transfers.
// Sustained rate is set by the output side draining the bundle queue (DEPTH entries).
// Reset (rst_n low, synchronous) returns to idle awaiting an opening quote, queue empty.
module quoted_literal_escape_decoder_unit import qled_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  logic    acc;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_wdata;
  bundle_t q_head;

  assign full = q_full;
  assign acc  = push && !q_full;

  qled_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc    (acc),
    .item   (in_item),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  qled_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  qled_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

`ifndef SYNTH
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.is_final) |-> out_item.last_of_run)
    else $error("final status not last of its run");

  a_final_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_item.is_final) |-> (out_item.char_value == 8'd0 && !out_item.escape_bad))
    else $error("final status carries a character");
`endif

endmodule

FILE: test/tb_quoted_literal_escape_decoder_unit.sv
// Self-checking testbench for the quoted literal escape decoder unit.
`timescale 1ns / 1ps

module tb_quoted_literal_escape_decoder_unit;
  import qled_pkg::*;

  localparam logic [7:0] QUOTE_D = 8'h22;
  localparam logic [7:0] QUOTE_S = 8'h27;
  localparam logic [7:0] BSLASH  = 8'h5C;
  localparam int RANDOM_BYTES    = 1550;

  typedef enum logic [2:0] {LIT_IDLE, LIT_BODY, LIT_ESCAPE, LIT_HEX, LIT_OCTAL} lit_phase_t;

  typedef struct {
    logic [7:0] src;
    logic       src_end;
    bit         typed;
    logic [7:0] val;
    logic       bad;
    logic       fin;
    logic [2:0] st;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_item;
  logic      empty;
  logic      pop;
  out_item_t out_item;

  quoted_literal_escape_decoder_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  // Decoder state as the predictor sees it
  lit_phase_t lit_phase = LIT_IDLE;
  logic       lit_single = 1'b0;
  logic [8:0] esc_value = '0;
  logic [3:0] esc_digits = '0;
  logic [1:0] char_count = '0;

  out_item_t  byte_results[$];
  out_item_t  expected_chars[$];

  string      escape_letters = "ntr\\\"'bfva";
  stim_row_t  directed_rows [27];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  results_checked = 0;
  int  bad_seen = 0;
  int  closes_seen = 0;
  int  hold_left = 0;
  bit  held_once = 1'b0;
  bit  drained_once = 1'b0;
  bit  quiet_window = 1'b0;

  function automatic void add_char(logic [7:0] v, logic bad);
    out_item_t r;
    if (char_count < 2) char_count++;
    r = '0;
    r.char_value = v;
    r.escape_bad = bad;
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void add_final(logic [2:0] st);
    out_item_t r;
    lit_phase  = LIT_IDLE;
    esc_value  = '0;
    esc_digits = '0;
    r = '0;
    r.is_final = 1'b1;
    r.literal_status = st;
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void close_octal();
    lit_phase = LIT_BODY;
    if (esc_value > 9'd255) add_char(BAD_CHAR, 1'b1);
    else add_char(esc_value[7:0], 1'b0);
  endfunction

  function automatic void body_char(logic [7:0] b);
    logic [7:0] q;
    q = lit_single ? QUOTE_S : QUOTE_D;
    if (b == q) begin
      if (!lit_single) add_final(ST_STRING_OK);
      else add_final(char_count == 2'd1 ? ST_CHAR_OK : ST_CHAR_LENGTH);
    end else if (b == BSLASH) begin
      lit_phase = LIT_ESCAPE;
    end else begin
      add_char(b, 1'b0);
    end
  endfunction

  function automatic void escape_char(logic [7:0] b);
    lit_phase = LIT_BODY;
    case (b)
      "n":  add_char(8'd10, 1'b0);
      "t":  add_char(8'd9, 1'b0);
      "\\": add_char(8'd92, 1'b0);
      "\"": add_char(8'd34, 1'b0);
      "'":  add_char(8'd39, 1'b0);
      "r":  add_char(8'd13, 1'b0);
      "b":  add_char(8'd8, 1'b0);
      "f":  add_char(8'd12, 1'b0);
      "v":  add_char(8'd11, 1'b0);
      "a":  add_char(8'd7, 1'b0);
      "x", "u", "U": begin
        lit_phase  = LIT_HEX;
        esc_value  = '0;
        esc_digits = (b == "x") ? 4'd2 : (b == "u") ? 4'd4 : 4'd8;
      end
      "0", "1", "2", "3", "4", "5", "6", "7": begin
        lit_phase  = LIT_OCTAL;
        esc_value  = {6'd0, b[2:0]};
        esc_digits = 4'd1;
      end
      default: add_char(BAD_CHAR, 1'b1);
    endcase
  endfunction

  function automatic int hex_value(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  // Work out every result that one accepted transfer causes
  function automatic void decode_byte(in_item_t it);
    logic [7:0] b;
    int d;
    b = it.source_byte;
    byte_results.delete();
    if (lit_phase == LIT_IDLE) begin
      if (it.source_end) begin
      end else if (b == QUOTE_S || b == QUOTE_D) begin
        lit_single = (b == QUOTE_S);
        char_count = '0;
        esc_value  = '0;
        esc_digits = '0;
        lit_phase  = LIT_BODY;
      end else begin
        add_final(ST_NOT_QUOTE);
      end
    end else if (it.source_end) begin
      // resolve a pending escape before the unterminated close
      if (lit_phase == LIT_ESCAPE || lit_phase == LIT_HEX) add_char(BAD_CHAR, 1'b1);
      else if (lit_phase == LIT_OCTAL) close_octal();
      add_final(ST_UNTERMINATED);
    end else begin
      case (lit_phase)
        LIT_BODY:   body_char(b);
        LIT_ESCAPE: escape_char(b);
        LIT_HEX: begin
          d = hex_value(b);
          if (d < 0) begin
            lit_phase = LIT_BODY;
            add_char(BAD_CHAR, 1'b1);
            body_char(b);
          end else begin
            esc_value = {1'b0, esc_value[3:0], d[3:0]};
            if (esc_digits > 0) esc_digits--;
            if (esc_digits == 0) begin
              lit_phase = LIT_BODY;
              add_char(esc_value[7:0], 1'b0);
            end
          end
        end
        default: begin
          if (b >= "0" && b <= "7") begin
            esc_value = {esc_value[5:0], b[2:0]};
            esc_digits++;
            if (esc_digits >= 3) close_octal();
          end else begin
            close_octal();
            body_char(b);
          end
        end
      endcase
    end
    if (byte_results.size() > 0) byte_results[$].last_of_run = 1'b1;
  endfunction

  // Offer one byte and hold it until the transfer; entered and left at a falling edge
  task automatic send_byte(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t typed_res = '0);
    bit ignored;
    while (!quiet_window && $urandom_range(0, 99) < 23) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    ignored = (lit_phase == LIT_IDLE) && it.source_end;
    decode_byte(it);
    if (typed) expected_chars.insert(expected_chars.size(), typed_res);
    else foreach (byte_results[k]) expected_chars.insert(expected_chars.size(), byte_results[k]);
    if (!ignored) bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_hex();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'("0" + k);
    if (k < 16) return 8'("a" + k - 10);
    return 8'("A" + k - 16);
  endfunction

  task automatic send_element(input logic single);
    logic [7:0] b;
    int digits;
    int n;
    case ($urandom_range(0, 9))
      4: begin
        send_byte({BSLASH, 1'b0});
        send_byte({8'(escape_letters[$urandom_range(0, 9)]), 1'b0});
      end
      5: begin
        send_byte({BSLASH, 1'b0});
        case ($urandom_range(0, 2))
          0: begin b = "x"; digits = 2; end
          1: begin b = "u"; digits = 4; end
          default: begin b = "U"; digits = 8; end
        endcase
        send_byte({b, 1'b0});
        // now and then cut the hex run short
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, digits - 1) : digits;
        repeat (n) send_byte({pick_hex(), 1'b0});
      end
      6, 7: begin
        send_byte({BSLASH, 1'b0});
        n = $urandom_range(1, 3);
        repeat (n) send_byte({8'("0" + $urandom_range(0, 7)), 1'b0});
      end
      8: begin
        send_byte({BSLASH, 1'b0});
        send_byte({8'($urandom_range(0, 255)), 1'b0});
      end
      9: begin
        send_byte({BSLASH, 1'b0});
        send_byte({8'("x"), 1'b0});
        send_byte({pick_hex(), 1'b0});
      end
      default: begin
        b = 8'($urandom_range(0, 255));
        if (b == BSLASH || b == (single ? QUOTE_S : QUOTE_D)) b = "z";
        send_byte({b, 1'b0});
      end
    endcase
  endtask

  task automatic send_literal();
    logic single;
    int n;
    if ($urandom_range(0, 9) == 0) send_byte({8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
    single = ($urandom_range(0, 2) == 0);
    send_byte({single ? QUOTE_S : QUOTE_D, 1'b0});
    if (single) n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1;
    else n = $urandom_range(0, 8);
    repeat (n) send_element(single);
    case ($urandom_range(0, 19))
      0, 1: send_byte({8'($urandom_range(0, 255)), 1'b1});
      2: ;  // leave it open: the next opening quote lands in the body
      default: send_byte({single ? QUOTE_S : QUOTE_D, 1'b0});
    endcase
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
      end else begin
        want = expected_chars.pop_front();
        check_field("char_value", want.char_value, out_item.char_value);
        check_field("escape_bad", want.escape_bad, out_item.escape_bad);
        check_field("is_final", want.is_final, out_item.is_final);
        check_field("literal_status", want.literal_status, out_item.literal_status);
        check_field("last_of_run", want.last_of_run, out_item.last_of_run);
      end
      results_checked++;
      if (out_item.escape_bad) bad_seen++;
      if (out_item.is_final) closes_seen++;
    end
  end

  // Result side: random stalls, one long hold-off to back the queue up
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_once && results_checked >= 250) begin
        held_once = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= rst_n && (quiet_window || $urandom_range(0, 99) >= 23);
      end
    end
  end

  initial begin
    rst_n   = 1'b0;
    push    = 1'b0;
    in_item = '0;
    directed_rows = '{
      '{8'h00,   1'b0, 1'b1, 8'h00,    1'b0, 1'b1, ST_NOT_QUOTE},
      '{8'hFF,   1'b0, 1'b1, 8'h00,    1'b0, 1'b1, ST_NOT_QUOTE},
      '{8'h41,   1'b1, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{QUOTE_D, 1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{8'hFF,   1'b0, 1'b1, 8'hFF,    1'b0, 1'b0, '0},
      '{8'h00,   1'b0, 1'b1, 8'h00,    1'b0, 1'b0, '0},
      '{BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{"q",     1'b0, 1'b1, BAD_CHAR, 1'b1, 1'b0, '0},
      '{BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{"x",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{"G",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{"4",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{"0",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{"0",     1'b0, 1'b1, BAD_CHAR, 1'b1, 1'b0, '0},
      '{BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{"7",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{QUOTE_D, 1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{QUOTE_S, 1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{"n",     1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{QUOTE_S, 1'b0, 1'b1, 8'h00,    1'b0, 1'b1, ST_CHAR_OK},
      '{QUOTE_S, 1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{QUOTE_S, 1'b0, 1'b1, 8'h00,    1'b0, 1'b1, ST_CHAR_LENGTH},
      '{QUOTE_D, 1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{BSLASH,  1'b0, 1'b0, 8'h00,    1'b0, 1'b0, '0},
      '{8'h5A,   1'b1, 1'b0, 8'h00,    1'b0, 1'b0, '0}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_byte({directed_rows[i].src, directed_rows[i].src_end}, directed_rows[i].typed,
                {directed_rows[i].val, directed_rows[i].bad, directed_rows[i].fin,
                 directed_rows[i].st, 1'b1});

    while (bytes_sent < RANDOM_BYTES + 25) begin
      quiet_window = (bytes_sent >= 700 && bytes_sent < 1000);
      if (!drained_once && bytes_sent >= 1250) begin
        // pause the sender until every outstanding result has come back
        drained_once = 1'b1;
        push <= 1'b0;
        do @(negedge clk); while (expected_chars.size() != 0);
      end
      send_literal();
    end
    quiet_window = 1'b0;
    push <= 1'b0;

    while (expected_chars.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    $display("Run covered %0d source bytes and %0d checked results", bytes_sent, results_checked);
    $display("with %0d bad escapes and %0d literal closes.", bad_seen, closes_seen);
    if (mismatches == 0) begin
      $display("quoted_literal_escape_decoder_unit regression: pass");
    end else begin
      $display("quoted_literal_escape_decoder_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results still outstanding", expected_chars.size());
    $display("quoted_literal_escape_decoder_unit regression: fail");
    $finish;
  end

endmodule
